// File: hw/rtl/dfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    // width of the payload count and of a store address
    localparam int CNT_W = 6;

    // framing characters
    localparam logic [7:0] START_MARK = 8'h40;
    localparam logic [7:0] CHECK_MARK = 8'h7E;

    // digit decode constants
    localparam logic [7:0] DIGIT_LIMIT     = 8'd58;
    localparam logic [7:0] DIGIT_OFS_NUM   = 8'd48;
    localparam logic [7:0] DIGIT_OFS_ALPHA = 8'd55;
    localparam int         HIGH_SHIFT      = 4;

    // command queue between parser and emitter
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_OUT
    } t_back_state;

    typedef enum logic {
        CMD_WRITE,
        CMD_EMIT
    } t_cmd_kind;

    // count is the store address for a write, the run length for an emit
    typedef struct packed {
        t_cmd_kind        kind;
        logic             ok;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // byte read as signed: below 58 (or negative) is a numeric digit
    function automatic logic [7:0] decode_digit(input logic [7:0] b);
        logic [7:0] d;
        if (b[7] || (b < DIGIT_LIMIT)) begin
            d = b - DIGIT_OFS_NUM;
        end else begin
            d = b - DIGIT_OFS_ALPHA;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_front
    import dfr_pkg::*;
#(
    parameter int PAYLOAD_SLOTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_q_status  i_q_status,
    output logic            o_push,
    output t_cmd            o_cmd
);

    localparam logic [CNT_W-1:0] STORE_DEPTH = CNT_W'(PAYLOAD_SLOTS - 1);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_high, n_high;
    logic             w_accept;
    logic             w_is_start;
    logic             w_is_check;
    logic             w_overflow;
    logic [7:0]       w_sum;

    // any beat may need a queue slot, so hold off while the queue is full
    assign o_stall    = i_q_status.full;
    assign w_accept   = i_valid && !i_q_status.full;
    assign w_is_start = (i_rx_byte == START_MARK);
    assign w_is_check = (i_rx_byte == CHECK_MARK);
    assign w_overflow = (r_count >= STORE_DEPTH);
    assign w_sum      = (r_high << HIGH_SHIFT) + decode_digit(i_rx_byte);

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            if (w_is_start) begin
                n_phase = PH_PAYLOAD;
            end else if (w_is_check) begin
                if (r_phase == PH_PAYLOAD) begin
                    n_phase = PH_HIGH;
                end
            end else begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        if (w_overflow) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_HIGH: n_phase = PH_LOW;
                    PH_LOW:  n_phase = PH_IDLE;
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // datapath and command generation
    always_comb begin
        n_count = r_count;
        n_xor   = r_xor;
        n_high  = r_high;
        o_push  = 1'b0;
        o_cmd   = '{kind: CMD_WRITE, ok: 1'b0, data: i_rx_byte, count: r_count};
        if (w_accept) begin
            if (w_is_start) begin
                n_count = '0;
                n_xor   = '0;
            end else if (!w_is_check) begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        if (!w_overflow) begin
                            o_push  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_xor   = r_xor ^ i_rx_byte;
                        end
                    end
                    PH_HIGH: begin
                        n_high = decode_digit(i_rx_byte);
                    end
                    PH_LOW: begin
                        n_high       = w_sum;
                        o_push       = 1'b1;
                        o_cmd.kind   = CMD_EMIT;
                        o_cmd.ok     = (w_sum == r_xor);
                        o_cmd.data   = '0;
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_xor   <= '0;
            r_high  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
            r_high  <= n_high;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_queue
    import dfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_fill, n_fill;

    assign o_cmd           = r_slot[r_rd_ptr];
    assign o_status.empty  = (r_fill == '0);
    assign o_status.full   = (r_fill == (Q_PTR_W + 1)'(Q_DEPTH));

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + (Q_PTR_W + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - (Q_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_back
    import dfr_pkg::*;
#(
    parameter int PAYLOAD_SLOTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_q_status  i_q_status,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_checksum_ok,
    output logic            o_has_byte,
    output logic [7:0]      o_payload_byte,
    output logic            o_last
);

    localparam int STORE_DEPTH = PAYLOAD_SLOTS - 1;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0]       r_mem [STORE_DEPTH];
    logic [7:0]       r_rd_data;
    t_back_state      r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ok, n_ok;
    logic             r_has_byte, n_has_byte;
    logic             w_write;
    logic             w_emit;
    logic             w_last;

    assign o_pop   = (r_state == BK_IDLE) && !i_q_status.empty;
    assign w_write = o_pop && (i_cmd.kind == CMD_WRITE);
    assign w_emit  = o_pop && (i_cmd.kind == CMD_EMIT);
    assign w_last  = !r_has_byte || ((r_idx + CNT_W'(1)) == r_count);

    // emitter next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_emit) begin
                    n_state = (i_cmd.count == '0) ? BK_OUT : BK_FETCH;
                end
            end
            BK_FETCH: n_state = BK_OUT;
            BK_OUT: begin
                if (!i_stall) begin
                    n_state = w_last ? BK_IDLE : BK_FETCH;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // run bookkeeping and result outputs
    always_comb begin
        n_idx      = r_idx;
        n_count    = r_count;
        n_ok       = r_ok;
        n_has_byte = r_has_byte;
        case (r_state)
            BK_IDLE: begin
                if (w_emit) begin
                    n_idx      = '0;
                    n_count    = i_cmd.count;
                    n_ok       = i_cmd.ok;
                    n_has_byte = (i_cmd.count != '0);
                end
            end
            BK_OUT: begin
                if (!i_stall && !w_last) begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign o_valid        = (r_state == BK_OUT);
    assign o_checksum_ok  = r_ok;
    assign o_has_byte     = r_has_byte;
    assign o_payload_byte = r_has_byte ? r_rd_data : 8'h00;
    assign o_last         = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_idx      <= '0;
            r_count    <= '0;
            r_ok       <= 1'b0;
            r_has_byte <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_count    <= n_count;
            r_ok       <= n_ok;
            r_has_byte <= n_has_byte;
        end
    end

    // payload store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[i_cmd.count[IDX_W-1:0]] <= i_cmd.data;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

endmodule

`default_nettype wire

// File: hw/rtl/xor_checked_frame_deframer.sv
// Frame parser for '@' payload '~' H L frames with an XOR checksum.
// Input channel: one received byte per beat (i_valid, o_stall, i_rx_byte).
// A parser classifies each byte, keeps the running XOR and count, and posts
// store writes and end-of-frame commands into a 4-entry queue. It takes a
// byte every cycle while the queue has room; o_stall rises when it is full.
// An emitter drains the queue, moving each stored byte into the payload store
// while idle, and for each completed frame gives a run of results, one per
// payload byte (or a single result with o_has_byte low for an empty payload),
// each flagged with o_checksum_ok and o_last on the final one. Each result
// with a byte needs a store read, then the output beat, as the payload store
// has a single read port. After the beat with the second digit, the command
// passes through the queue and a store read (none for an empty payload) before
// the first result is shown. An overflowed frame yields no results.
// When the receiver stalls the current result holds; the queue keeps
// absorbing bytes until it fills, then the input side stalls too.
// Reset (synchronous, active low) returns to waiting for a start character
// and empties the queue; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_deframer
    import dfr_pkg::*;
#(
    parameter int PAYLOAD_SLOTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_checksum_ok,
    output logic            o_has_byte,
    output logic [7:0]      o_payload_byte,
    output logic            o_last
);

    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;

    dfr_front #(
        .PAYLOAD_SLOTS(PAYLOAD_SLOTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_q_status(w_q_status),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    dfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_status(w_q_status)
    );

    dfr_back #(
        .PAYLOAD_SLOTS(PAYLOAD_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_checksum_ok (o_checksum_ok),
        .o_has_byte    (o_has_byte),
        .o_payload_byte(o_payload_byte),
        .o_last        (o_last)
    );

    // parser never posts into a full queue
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full)
    ) else $error("command pushed into full queue");

    // an empty-payload result is a single beat with a zero byte
    a_empty_run_shape: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> (o_last && (o_payload_byte == 8'h00))
    ) else $error("empty-payload result malformed");

    // inside a run, each byte needs a store read before the next beat
    a_run_refetch: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> !o_valid
    ) else $error("result shown without a store read");

endmodule

`default_nettype wire

// File: dv/xor_checked_frame_deframer_tb.sv
`timescale 1ns / 1ps

module xor_checked_frame_deframer_tb
    import dfr_pkg::*;
;

    localparam int STORE_DEPTH = 63;

    typedef struct packed {
        logic       ok;
        logic       has_byte;
        logic [7:0] data;
        logic       last;
    } t_frame_result;

    // how the two checksum characters of a generated frame are formed
    typedef enum {
        DIG_GOOD,
        DIG_WRONG,
        DIG_RAW
    } t_digit_mode;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    wire        o_stall;
    wire        o_valid;
    wire        o_checksum_ok;
    wire        o_has_byte;
    wire  [7:0] o_payload_byte;
    wire        o_last;

    int            mismatches = 0;
    bit            quiet_run  = 1'b0;
    t_frame_result expected_results[$];

    // parser state mirrored in the testbench
    t_phase           rx_phase;
    logic [CNT_W-1:0] rx_count;
    logic [7:0]       rx_store [STORE_DEPTH];
    logic [7:0]       rx_xor;
    logic [7:0]       rx_high;

    xor_checked_frame_deframer #(
        .PAYLOAD_SLOTS(64)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_checksum_ok (o_checksum_ok),
        .o_has_byte    (o_has_byte),
        .o_payload_byte(o_payload_byte),
        .o_last        (o_last)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        i_stall = i_rst_n && !quiet_run && ($urandom_range(99) < 13);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // compare every output beat with the oldest expected result
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, byte %02h", o_payload_byte));
            end else begin
                want = expected_results.pop_front();
                check_field("checksum_ok", o_checksum_ok, want.ok);
                check_field("has_byte", o_has_byte, want.has_byte);
                check_field("payload_byte", o_payload_byte, want.data);
                check_field("last", o_last, want.last);
            end
        end
    end

    // checksum character: signed byte below 58 is numeric, else alphabetic offset
    function automatic logic [7:0] digit_value(input logic [7:0] b);
        if ($signed(b) < $signed(DIGIT_LIMIT)) begin
            return b - DIGIT_OFS_NUM;
        end
        return b - DIGIT_OFS_ALPHA;
    endfunction

    // advance the mirrored parser by one received byte
    task automatic predict_rx(input logic [7:0] b);
        logic [7:0]    sum;
        logic          ok;
        t_frame_result r;
        if (b == START_MARK) begin
            rx_phase = PH_PAYLOAD;
            rx_count = '0;
            rx_xor   = 8'h00;
        end else if (b == CHECK_MARK) begin
            if (rx_phase == PH_PAYLOAD) begin
                rx_phase = PH_HIGH;
            end
        end else begin
            case (rx_phase)
                PH_PAYLOAD: begin
                    // full store drops the frame
                    if (rx_count >= STORE_DEPTH) begin
                        rx_phase = PH_IDLE;
                    end else begin
                        rx_store[rx_count] = b;
                        rx_count = rx_count + CNT_W'(1);
                        rx_xor   = rx_xor ^ b;
                    end
                end
                PH_HIGH: begin
                    rx_high  = digit_value(b);
                    rx_phase = PH_LOW;
                end
                PH_LOW: begin
                    sum      = (rx_high << HIGH_SHIFT) + digit_value(b);
                    ok       = (sum == rx_xor);
                    rx_high  = sum;
                    rx_phase = PH_IDLE;
                    // empty payload still reports its checksum
                    if (rx_count == 0) begin
                        r = '{ok: ok, has_byte: 1'b0, data: 8'h00, last: 1'b1};
                        expected_results.push_back(r);
                    end else begin
                        for (int i = 0; i < rx_count; i++) begin
                            r = '{ok: ok, has_byte: 1'b1, data: rx_store[i],
                                  last: (i == rx_count - 1)};
                            expected_results.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_rx(input logic [7:0] b);
        @(negedge i_clk);
        while (!quiet_run && ($urandom_range(99) < 13)) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_rx(b);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return 8'h41 + n - 8'd10;
    endfunction

    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == START_MARK || b == CHECK_MARK);
        return b;
    endfunction

    task automatic send_frame(input int len, input t_digit_mode mode);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_rx(START_MARK);
        for (int i = 0; i < len; i++) begin
            b   = rand_payload();
            sum = sum ^ b;
            send_rx(b);
        end
        send_rx(CHECK_MARK);
        if (mode == DIG_WRONG) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        if (mode == DIG_RAW) begin
            send_rx(8'($urandom_range(255)));
            send_rx(8'($urandom_range(255)));
        end else begin
            send_rx(hex_char(sum[7:4]));
            send_rx(hex_char(sum[3:0]));
        end
    endtask

    task automatic test_empty_payload();
        send_rx(START_MARK);
        send_rx(CHECK_MARK);
        send_rx("0");
        send_rx("0");
    endtask

    // payload extremes, checksum 7E
    task automatic test_extremes();
        send_rx(START_MARK);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h01);
        send_rx(8'h80);
        send_rx(CHECK_MARK);
        send_rx("7");
        send_rx("E");
    endtask

    // junk in idle, restart mid payload, check mark while awaiting a digit
    task automatic test_stray_markers();
        send_rx("X");
        send_rx(CHECK_MARK);
        send_rx(START_MARK);
        send_rx("A");
        send_rx(START_MARK);
        send_rx("B");
        send_rx(CHECK_MARK);
        send_rx(CHECK_MARK);
        send_rx("4");
        send_rx("2");
    endtask

    // negative bytes as digits, and the boundary right at 58
    task automatic test_signed_digits();
        send_rx(START_MARK);
        send_rx(CHECK_MARK);
        send_rx(8'h80);
        send_rx(8'hFF);
        send_rx(START_MARK);
        send_rx(8'h33);
        send_rx(CHECK_MARK);
        send_rx(":");
        send_rx("3");
    endtask

    task automatic test_full_store();
        send_frame(STORE_DEPTH, DIG_GOOD);
    endtask

    // one byte past the store drops the frame; the tail is then ignored
    task automatic test_overflow();
        send_rx(START_MARK);
        for (int i = 0; i <= STORE_DEPTH; i++) begin
            send_rx(rand_payload());
        end
        send_rx(CHECK_MARK);
        send_rx("0");
        send_rx("0");
        send_frame(2, DIG_GOOD);
    endtask

    task automatic test_drain_pause();
        send_frame(5, DIG_GOOD);
        wait_drained();
        send_frame(3, DIG_WRONG);
    endtask

    task automatic test_random_frames();
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < 260) begin
            // a stretch with no idling on either side
            quiet_run = (sent >= 80 && sent < 160);
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            if (pick < 70) begin
                send_frame(len, DIG_GOOD);
                sent += len + 4;
            end else if (pick < 80) begin
                send_frame(len, DIG_WRONG);
                sent += len + 4;
            end else if (pick < 88) begin
                send_frame(len, DIG_RAW);
                sent += len + 4;
            end else if (pick < 94) begin
                // frame cut short by the next start
                len = $urandom_range(0, 6);
                send_rx(START_MARK);
                repeat (len) send_rx(rand_payload());
                sent += len + 1;
                if ($urandom_range(1) == 1) begin
                    send_rx(CHECK_MARK);
                    send_rx(hex_char(4'($urandom_range(15))));
                    sent += 2;
                end
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) send_rx(8'($urandom_range(255)));
                sent += len;
            end
            if ($urandom_range(99) < 4) begin
                wait_drained();
            end
        end
        quiet_run = 1'b0;
    endtask

    initial begin
        rx_phase = PH_IDLE;
        rx_count = '0;
        rx_xor   = 8'h00;
        rx_high  = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_payload();
        test_extremes();
        test_stray_markers();
        test_signed_digits();
        test_full_store();
        test_overflow();
        test_drain_pause();
        test_random_frames();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
